// ===== rtl/poly1305_mac_engine_defines.svh =====
// Assertion macros shared by the Poly1305 MAC engine modules.
`ifndef POLY1305_MAC_ENGINE_DEFINES_SVH
`define POLY1305_MAC_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define P1305_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define P1305_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/p1305_pkg.sv =====
// Shared widths, key clamp masks, register indexes and control types for the Poly1305 engine.
package p1305_pkg;

	localparam int LIMB_W    = 26;
	localparam int NLIMB     = 5;
	localparam int H_W       = 28;
	localparam int COEF_W    = 29;
	localparam int PROD_W    = H_W + COEF_W;
	localparam int D_W       = 60;
	localparam int FOLD_W    = D_W - LIMB_W + 3;
	localparam int P_W       = 130;
	localparam int G_W       = P_W + 1;
	localparam int V_W       = P_W + 2;
	localparam int REG_W     = 64;
	localparam int BLK_W     = 128;
	localparam int TAG_W     = 128;
	localparam int CNT_W     = 5;
	localparam int BLK_BYTES = 16;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W    = 3;
	localparam int P_FOLD    = 5;

	localparam logic [STEP_W-1:0] MAC_LAST   = STEP_W'(NLIMB - 1);
	localparam logic [STEP_W-1:0] CARRY_LAST = STEP_W'(2);

	localparam logic [REG_W-1:0] R_LO_CLAMP = 64'h0fff_fffc_0fff_ffff;
	localparam logic [REG_W-1:0] R_HI_CLAMP = 64'h0fff_fffc_0fff_fffc;

	localparam logic [CFG_IDX_W-1:0] REG_R_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_R_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_S_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_S_HI = 2'd3;

	typedef logic [LIMB_W-1:0] limb_t;
	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [H_W-1:0]    hlimb_t;
	typedef logic [D_W-1:0]    dlimb_t;

	typedef struct packed {
		logic              load;
		logic              mac;
		logic              carry;
		logic              carry_last;
		logic              fcomp;
		logic              fold1;
		logic              fold2;
		logic              fsel;
		logic              tag_load;
		logic [STEP_W-1:0] step;
	} p1305_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic out_busy;
	} p1305_sts_t;

endpackage

// ===== rtl/p1305_ctrl.sv =====
// Sequencer for block absorb, multiply steps, carry rounds and final tag reduction.
`include "poly1305_mac_engine_defines.svh"

module p1305_ctrl import p1305_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_last,
	output logic       in_ready,
	input  p1305_sts_t sts,
	output p1305_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_CARRY = 3'd2;
	localparam logic [2:0] S_FCOMP = 3'd3;
	localparam logic [2:0] S_FOLD1 = 3'd4;
	localparam logic [2:0] S_FOLD2 = 3'd5;
	localparam logic [2:0] S_FSEL  = 3'd6;
	localparam logic [2:0] S_TAG   = 3'd7;

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              last_q, last_d;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		last_d   = last_q;
		cmd      = '0;
		cmd.step = step_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					last_d   = in_last;
					step_d   = '0;
					if (!sts.cnt_zero) begin
						state_d = S_MUL;
					end else if (in_last) begin
						state_d = S_FCOMP;
					end
				end
			end
			S_MUL: begin
				cmd.mac = 1'b1;
				if (step_q == MAC_LAST) begin
					state_d = S_CARRY;
					step_d  = '0;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			S_CARRY: begin
				cmd.carry = 1'b1;
				if (step_q == CARRY_LAST) begin
					cmd.carry_last = 1'b1;
					state_d        = last_q ? S_FCOMP : S_IDLE;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			S_FCOMP: begin
				cmd.fcomp = 1'b1;
				state_d   = S_FOLD1;
			end
			S_FOLD1: begin
				cmd.fold1 = 1'b1;
				state_d   = S_FOLD2;
			end
			S_FOLD2: begin
				cmd.fold2 = 1'b1;
				state_d   = S_FSEL;
			end
			S_FSEL: begin
				cmd.fsel = 1'b1;
				state_d  = S_TAG;
			end
			S_TAG: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.tag_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			last_q  <= last_d;
		end
	end

	`P1305_ASSERT_NOW(a_mul_step_range, state_q == S_MUL, step_q <= MAC_LAST, "multiply step out of range")
	`P1305_ASSERT_NEXT(a_accept_to_mul, cmd.load && !sts.cnt_zero, (state_q == S_MUL) && (step_q == '0), "nonempty word did not start multiply")
	`P1305_ASSERT_NEXT(a_carry_to_idle, (state_q == S_CARRY) && (step_q == CARRY_LAST) && !last_q, in_ready, "not ready after inner block")

endmodule

// ===== rtl/p1305_dp.sv =====
// Key registers, accumulator limbs, multiply-accumulate lanes, final reduction and tag register.
`include "poly1305_mac_engine_defines.svh"

module p1305_dp import p1305_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	input  logic [BLK_W-1:0]     blk_data,
	input  logic [CNT_W-1:0]     blk_count,
	input  p1305_cmd_t           cmd,
	output p1305_sts_t           sts,
	output logic                 tag_valid,
	input  logic                 tag_ready,
	output logic [TAG_W-1:0]     tag_data
);

	logic [REG_W-1:0] r_lo_q, r_hi_q, s_lo_q, s_hi_q;
	limb_t            r_q  [NLIMB];
	coef_t            s5_q [NLIMB];
	hlimb_t           h_q  [NLIMB];
	dlimb_t           d_q  [NLIMB];
	logic [V_W-1:0]   v_q;
	logic [TAG_W-1:0] tag_q;
	logic             tag_valid_q;

	logic [BLK_W-1:0]  r_full;
	limb_t             r_n  [NLIMB];
	coef_t             s5_n [NLIMB];
	logic [CNT_W-1:0]  cnt_sat;
	logic [BLK_W:0]    pad_blk;
	limb_t             t_n  [NLIMB];
	hlimb_t            hop;
	coef_t             coef [NLIMB];
	logic [PROD_W-1:0] prod [NLIMB];
	dlimb_t            mac_n [NLIMB];
	dlimb_t            dc   [NLIMB];
	logic [FOLD_W-1:0] fold;
	logic [V_W-1:0]    v_base, v_cy, v_comp, v_f1, v_f2, v_fs;
	logic [3:0]        top5;
	logic [G_W-1:0]    g;

	// clamp r and split into 26-bit limbs; precompute 5*r for the wrapped columns
	always_comb begin
		r_full = {r_hi_q & R_HI_CLAMP, r_lo_q & R_LO_CLAMP};
		for (int i = 0; i < NLIMB - 1; i++) begin
			r_n[i] = r_full[LIMB_W*i +: LIMB_W];
		end
		r_n[NLIMB-1] = LIMB_W'(r_full[BLK_W-1:LIMB_W*(NLIMB-1)]);
		for (int i = 0; i < NLIMB; i++) begin
			s5_n[i] = COEF_W'({r_n[i], 2'b00}) + COEF_W'(r_n[i]);
		end
	end

	// drop bytes past the count and place the pad byte right after them
	always_comb begin
		cnt_sat = (blk_count > CNT_W'(BLK_BYTES)) ? CNT_W'(BLK_BYTES) : blk_count;
		pad_blk = '0;
		for (int k = 0; k < BLK_BYTES; k++) begin
			if (CNT_W'(k) < cnt_sat) begin
				pad_blk[8*k +: 8] = blk_data[8*k +: 8];
			end else if (CNT_W'(k) == cnt_sat) begin
				pad_blk[8*k +: 8] = 8'h01;
			end
		end
		pad_blk[BLK_W] = (cnt_sat == CNT_W'(BLK_BYTES));
		for (int i = 0; i < NLIMB - 1; i++) begin
			t_n[i] = pad_blk[LIMB_W*i +: LIMB_W];
		end
		t_n[NLIMB-1] = LIMB_W'(pad_blk[BLK_W:LIMB_W*(NLIMB-1)]);
	end

	// step j multiplies h[j] into every column; columns below j wrap with 5*r
	always_comb begin
		case (cmd.step)
			3'd0: begin
				hop  = h_q[0];
				coef = '{COEF_W'(r_q[0]), COEF_W'(r_q[1]), COEF_W'(r_q[2]),
					COEF_W'(r_q[3]), COEF_W'(r_q[4])};
			end
			3'd1: begin
				hop  = h_q[1];
				coef = '{s5_q[4], COEF_W'(r_q[0]), COEF_W'(r_q[1]),
					COEF_W'(r_q[2]), COEF_W'(r_q[3])};
			end
			3'd2: begin
				hop  = h_q[2];
				coef = '{s5_q[3], s5_q[4], COEF_W'(r_q[0]),
					COEF_W'(r_q[1]), COEF_W'(r_q[2])};
			end
			3'd3: begin
				hop  = h_q[3];
				coef = '{s5_q[2], s5_q[3], s5_q[4], COEF_W'(r_q[0]), COEF_W'(r_q[1])};
			end
			3'd4: begin
				hop  = h_q[4];
				coef = '{s5_q[1], s5_q[2], s5_q[3], s5_q[4], COEF_W'(r_q[0])};
			end
			default: begin
				hop  = '0;
				coef = '{default: '0};
			end
		endcase
		for (int i = 0; i < NLIMB; i++) begin
			prod[i]  = PROD_W'(hop) * PROD_W'(coef[i]);
			mac_n[i] = ((cmd.step == '0) ? '0 : d_q[i]) + D_W'(prod[i]);
		end
	end

	// one parallel carry round; the top carry folds back times five
	always_comb begin
		fold  = FOLD_W'({d_q[NLIMB-1][D_W-1:LIMB_W], 2'b00}) +
			FOLD_W'(d_q[NLIMB-1][D_W-1:LIMB_W]);
		dc[0] = D_W'(d_q[0][LIMB_W-1:0]) + D_W'(fold);
		for (int i = 1; i < NLIMB; i++) begin
			dc[i] = D_W'(d_q[i][LIMB_W-1:0]) + D_W'(d_q[i-1][D_W-1:LIMB_W]);
		end
	end

	// final reduction: compose, fold twice, then subtract p if not below it
	always_comb begin
		v_base = '0;
		v_cy   = '0;
		for (int i = 0; i < NLIMB; i++) begin
			v_base[LIMB_W*i +: LIMB_W]   = h_q[i][LIMB_W-1:0];
			v_cy[LIMB_W*(i+1) +: 2]      = h_q[i][H_W-1:LIMB_W];
		end
		v_comp = v_base + v_cy;
		top5   = 4'({v_q[V_W-1:P_W], 2'b00}) + 4'(v_q[V_W-1:P_W]);
		v_f1   = V_W'(v_q[P_W-1:0]) + V_W'(top5);
		v_f2   = V_W'(v_q[P_W-1:0]) + (v_q[P_W] ? V_W'(P_FOLD) : '0);
		g      = v_q[G_W-1:0] + G_W'(P_FOLD);
		v_fs   = g[P_W] ? V_W'(g[P_W-1:0]) : v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_lo_q <= '0;
			r_hi_q <= '0;
			s_lo_q <= '0;
			s_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_R_LO: r_lo_q <= cfg_wdata;
				REG_R_HI: r_hi_q <= cfg_wdata;
				REG_S_LO: s_lo_q <= cfg_wdata;
				REG_S_HI: s_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NLIMB; i++) begin
			r_q[i]  <= r_n[i];
			s5_q[i] <= s5_n[i];
			if (cmd.mac) begin
				d_q[i] <= mac_n[i];
			end else if (cmd.carry) begin
				d_q[i] <= dc[i];
			end
		end
		if (cmd.fcomp) begin
			v_q <= v_comp;
		end else if (cmd.fold1) begin
			v_q <= v_f1;
		end else if (cmd.fold2) begin
			v_q <= v_f2;
		end else if (cmd.fsel) begin
			v_q <= v_fs;
		end
		if (cmd.tag_load) begin
			tag_q <= v_q[TAG_W-1:0] + {s_hi_q, s_lo_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NLIMB; i++) begin
				h_q[i] <= '0;
			end
			tag_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < NLIMB; i++) begin
				if (cmd.tag_load) begin
					h_q[i] <= '0;
				end else if (cmd.carry_last) begin
					h_q[i] <= dc[i][H_W-1:0];
				end else if (cmd.load && !sts.cnt_zero) begin
					h_q[i] <= h_q[i] + H_W'(t_n[i]);
				end
			end
			if (cmd.tag_load) begin
				tag_valid_q <= 1'b1;
			end else if (tag_ready) begin
				tag_valid_q <= 1'b0;
			end
		end
	end

	assign sts.cnt_zero = (blk_count == '0);
	assign sts.out_busy = tag_valid_q && !tag_ready;
	assign tag_valid    = tag_valid_q;
	assign tag_data     = tag_q;

	`P1305_ASSERT_NEXT(a_tag_clears_acc, cmd.tag_load, tag_valid_q && (h_q[0] == '0) && (h_q[1] == '0) && (h_q[2] == '0) && (h_q[3] == '0) && (h_q[4] == '0), "tag load did not clear accumulator")
	`P1305_ASSERT_NEXT(a_fsel_reduced, cmd.fsel, v_q[V_W-1:P_W] == 2'b00, "reduced value above 130 bits")
	`P1305_ASSERT_NEXT(a_carry_bound, cmd.carry_last, !h_q[0][H_W-1] && !h_q[1][H_W-1] && !h_q[2][H_W-1] && !h_q[3][H_W-1] && !h_q[4][H_W-1], "limb past bound after carry")

endmodule

// ===== rtl/poly1305_mac_engine.sv =====
// Poly1305 MAC engine top level: stream ports, key write port, controller and datapath.
//
//  channel  | dir | payload                                   | handshake
//  s_axis   | in  | tdata: block_low, block_high; tuser: byte_count; tlast: last_block | tvalid/tready
//  m_axis   | out | tdata: tag_low, tag_high                  | tvalid/tready
//  cfg      | in  | cfg_index 0..3: r_low, r_high, s_low, s_high; cfg_wdata | cfg_we
//
// A block with a nonzero count runs from acceptance to the next ready through one absorb
// step, five multiply-accumulate steps (one accumulator limb across five lanes each) and three
// carry rounds. A zero-count word skips the multiply and carry steps. A last word adds the final
// reduction and the s addition; the tag step waits while the output register holds an untaken tag.
// Reset clears the accumulator, key registers and output valid; no clearing pass follows.
module poly1305_mac_engine import p1305_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [BLK_W-1:0]     s_axis_tdata,   // [63:0] block_low, [127:64] block_high
	input  logic [CNT_W-1:0]     s_axis_tuser,   // [4:0] byte_count
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TAG_W-1:0]     m_axis_tdata,   // [63:0] tag_low, [127:64] tag_high
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata
);

	p1305_cmd_t cmd;
	p1305_sts_t sts;

	p1305_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	p1305_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.blk_data  (s_axis_tdata),
		.blk_count (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.tag_valid (m_axis_tvalid),
		.tag_ready (m_axis_tready),
		.tag_data  (m_axis_tdata)
	);

endmodule
